// ===== sv/assert_macros.svh =====
// Assertion macros shared by the complex vector norm RTL.
// Included by the controller and the datapath; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Check a property on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== sv/cvnorm_pkg.sv =====
// Package for the complex vector norm block: widths, item structs and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package cvnorm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 42;
  localparam int NORM_BITS   = 21;
  localparam int SQRT_STEPS  = NORM_BITS;
  localparam int STEP_W      = $clog2(SQRT_STEPS);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] real_part;
    logic signed [SAMPLE_BITS-1:0] imag_part;
    logic                          last_element;
  } in_item_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] norm_value;
    logic                 overflowed;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic sqrt_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/cvnorm_datapath.sv =====
// Datapath of the complex vector norm: input register, squaring stage,
// saturating accumulator, bit-serial square root and output register.
// Depends on cvnorm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cvnorm_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cvnorm_pkg::dp_cmd_t   cmd_i,
  output cvnorm_pkg::dp_status_t status_o,
  input  cvnorm_pkg::in_item_t  in_item_i,
  output cvnorm_pkg::out_item_t out_item_o
);
  import cvnorm_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int TERM_W = PROD_W;
  localparam int REM_W  = NORM_BITS + 3;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  in_item_t                  in_q;
  logic signed [PROD_W-1:0]  sq_re_q, sq_im_q;
  logic [SUM_BITS-1:0]       sum_q, sum_d;
  logic                      sat_q, sat_d;
  logic [SUM_BITS-1:0]       rad_q, rad_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic [NORM_BITS-1:0]      root_q, root_d;
  logic                      ovf_q, ovf_d;
  out_item_t                 out_q;

  logic [TERM_W-1:0]         term;
  logic [SUM_BITS:0]         total;
  logic [SUM_BITS-1:0]       total_sat;
  logic                      sat_new;
  logic [REM_W-1:0]          rem_sh, trial;

  // Squares are nonnegative and at most 2^(PROD_W-2), so the sign bit drops.
  assign term = {1'b0, sq_re_q[PROD_W-2:0]} + {1'b0, sq_im_q[PROD_W-2:0]};
  assign total = {1'b0, sum_q} + (SUM_BITS+1)'(term);
  assign total_sat = total[SUM_BITS] ? SUM_MAX : total[SUM_BITS-1:0];
  assign sat_new = sat_q | total[SUM_BITS];

  // One root bit per cycle: bring in two radicand bits, try root*4+1.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_BITS-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_comb begin
    sum_d  = sum_q;
    sat_d  = sat_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    ovf_d  = ovf_q;
    if (cmd_i.accum) begin
      if (in_q.last_element) begin
        // Hand the total to the root unit and clear for the next vector.
        sum_d  = '0;
        sat_d  = 1'b0;
        rad_d  = total_sat;
        rem_d  = '0;
        root_d = '0;
        ovf_d  = sat_new;
      end else begin
        sum_d = total_sat;
        sat_d = sat_new;
      end
    end
    if (cmd_i.sqrt_step) begin
      rad_d = {rad_q[SUM_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[NORM_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[NORM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    ovf_q  <= ovf_d;
    if (cmd_i.load_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.square) begin
      sq_re_q <= in_q.real_part * in_q.real_part;
      sq_im_q <= in_q.imag_part * in_q.imag_part;
    end
    if (cmd_i.load_out) begin
      out_q.norm_value <= root_q;
      out_q.overflowed <= ovf_q;
    end
  end

  assign status_o.last = in_q.last_element;
  assign out_item_o    = out_q;

  // A saturated sum stays pinned at its maximum until it is cleared.
  `ASSERT_CLK(a_sat_pins_sum, clk_i, rst_ni, sat_q |-> (sum_q == SUM_MAX))
  // Square root invariant: the remainder never exceeds twice the partial root.
  `ASSERT_CLK(a_rem_bound, clk_i, rst_ni,
              $past(cmd_i.sqrt_step) |-> (rem_q <= REM_W'({root_q, 1'b0})))

endmodule

`default_nettype wire

// ===== sv/cvnorm_ctrl.sv =====
// Controller of the complex vector norm: sequences input capture, squaring,
// accumulation, the root iterations and the output handshake.
// Depends on cvnorm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cvnorm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cvnorm_pkg::dp_cmd_t    cmd_o,
  input  cvnorm_pkg::dp_status_t status_i
);
  import cvnorm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic              out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load_in   = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.square    = (state_q == ST_SQUARE);
  assign cmd_o.accum     = (state_q == ST_ACCUM);
  assign cmd_o.sqrt_step = (state_q == ST_SQRT);
  assign cmd_o.load_out  = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid as the root lands in the output register; drop it on accept.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          state_q <= ST_ACCUM;
        end
        ST_ACCUM: begin
          step_q  <= '0;
          state_q <= status_i.last ? ST_SQRT : ST_IDLE;
        end
        ST_SQRT: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the finished root until the output register frees up.
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only appears after the root unit has finished.
  `ASSERT_CLK(a_valid_from_done, clk_i, rst_ni,
              (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_DONE))
  // The root unit never runs past its last step.
  `ASSERT_CLK(a_step_bound, clk_i, rst_ni,
              (state_q == ST_SQRT) |-> (step_q <= STEP_W'(SQRT_STEPS - 1)))

endmodule

`default_nettype wire

// ===== sv/complex_vector_euclidean_norm_top.sv =====
// Top level of the complex vector norm block: joins controller and datapath.
// Depends on cvnorm_pkg, cvnorm_ctrl and cvnorm_datapath.
//
// Streams complex elements (signed Q1.15 real and imaginary parts) and
// accumulates re*re + im*im into a 42-bit Q.30 sum that saturates at its
// maximum and sets a sticky overflow flag. On the element marked last, the
// block returns floor(sqrt(sum)) as a 21-bit Q.15 norm with the flag, then
// clears the sum. An element that is not last is captured, squared and
// accumulated. A last element then runs the root steps until its result
// is in the output register: the square root resolves one root bit per
// cycle in a single shared add/compare unit.
// A finished result waits in the output register while the next element
// is accepted.
`default_nettype none

module complex_vector_euclidean_norm_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cvnorm_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cvnorm_pkg::out_item_t out_item_o
);
  import cvnorm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cvnorm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cvnorm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ===== test/complex_vector_euclidean_norm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the complex vector norm block: watches both item channels,
// predicts each norm from the accepted elements and compares. Uses cvnorm_pkg.
module complex_vector_euclidean_norm_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  cvnorm_pkg::in_item_t  in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  cvnorm_pkg::out_item_t out_item_i,
  output int                    mismatch_count_o,
  output int                    norms_outstanding_o
);
  import cvnorm_pkg::*;

  localparam logic [SUM_BITS-1:0] SUM_LIMIT = '1;

  logic [SUM_BITS-1:0] sum_of_squares = '0;
  logic                sum_clipped    = 1'b0;
  out_item_t           norm_queue[$];
  int                  mismatches     = 0;
  int                  outstanding    = 0;

  assign mismatch_count_o    = mismatches;
  assign norms_outstanding_o = outstanding;

  // re*re + im*im of one element; the sign drops out of each square.
  function automatic logic [SUM_BITS:0] element_power(in_item_t item);
    longint re;
    longint im;
    re = longint'($signed(item.real_part));
    im = longint'($signed(item.imag_part));
    return (SUM_BITS + 1)'(re * re + im * im);
  endfunction

  // Largest root whose square does not exceed value, found bit by bit from the top.
  function automatic logic [NORM_BITS-1:0] floor_root(logic [SUM_BITS-1:0] value);
    logic [NORM_BITS-1:0]   root;
    logic [NORM_BITS-1:0]   trial;
    logic [2*NORM_BITS-1:0] square;
    root = '0;
    for (int b = NORM_BITS - 1; b >= 0; b--) begin
      trial  = root | (NORM_BITS'(1) << b);
      square = trial * trial;
      if (square <= value) root = trial;
    end
    return root;
  endfunction

  always @(posedge clk_i) begin
    logic [SUM_BITS:0] total;
    out_item_t         want;
    if (!rst_ni) begin
      sum_of_squares = '0;
      sum_clipped    = 1'b0;
      norm_queue.delete();
    end else begin
      // Check the outgoing item first: a norm leaving now was predicted earlier.
      if (out_valid_i && out_ready_i) begin
        if (norm_queue.size() == 0) begin
          $error("unexpected norm item: norm_value %0d overflowed %0b",
                 out_item_i.norm_value, out_item_i.overflowed);
          mismatches++;
        end else begin
          want = norm_queue.pop_front();
          if (out_item_i.norm_value !== want.norm_value) begin
            $error("norm_value: expected %0d, got %0d", want.norm_value,
                   out_item_i.norm_value);
            mismatches++;
          end
          if (out_item_i.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b, got %0b", want.overflowed,
                   out_item_i.overflowed);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        total = {1'b0, sum_of_squares} + element_power(in_item_i);
        // Hold at the top on overflow; landing exactly on the top is no overflow.
        if (total > {1'b0, SUM_LIMIT}) begin
          total       = {1'b0, SUM_LIMIT};
          sum_clipped = 1'b1;
        end
        sum_of_squares = total[SUM_BITS-1:0];
        if (in_item_i.last_element) begin
          want.norm_value = floor_root(sum_of_squares);
          want.overflowed = sum_clipped;
          norm_queue.push_back(want);
          sum_of_squares = '0;
          sum_clipped    = 1'b0;
        end
      end
    end
    outstanding = norm_queue.size();
  end

endmodule

// ===== test/complex_vector_euclidean_norm_top_test.sv =====
`timescale 1ns / 1ps
// Testbench top for complex_vector_euclidean_norm_top: drives element vectors
// and output stalls, gives the verdict. Uses cvnorm_pkg and the norm checker.
module complex_vector_euclidean_norm_top_test;
  import cvnorm_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = 16'sh7FFF;
  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_TAIL   = 150;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  bit        idle_on   = 1'b1;
  int        stall_left = 0;
  int        mismatch_count;
  int        norms_outstanding;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  complex_vector_euclidean_norm_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  complex_vector_euclidean_norm_checker norm_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready_o),
    .in_item_i           (in_item),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready),
    .out_item_i          (out_item_o),
    .mismatch_count_o    (mismatch_count),
    .norms_outstanding_o (norms_outstanding)
  );

  // Stall the result side in random bursts while idle_on is set.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] random_part();
    case ($urandom_range(0, 9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return 16'sd0;
      3:       return -16'sd1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Present one element, after an occasional idle gap, and hold it until accepted; keep valid high afterward.
  task automatic send_element(input logic signed [SAMPLE_BITS-1:0] re,
                              input logic signed [SAMPLE_BITS-1:0] im,
                              input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= '{real_part: re, imag_part: im, last_element: last};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int items_sent;
    int vec_len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-element vectors at the extremes.
    send_element(16'sd0, 16'sd0, 1'b1);
    send_element(MOST_NEG, MOST_NEG, 1'b1);
    send_element(MOST_POS, MOST_POS, 1'b1);
    send_element(MOST_NEG, MOST_POS, 1'b1);
    send_element(16'sd1, -16'sd1, 1'b1);
    send_element(-16'sd1, 16'sd0, 1'b1);
    send_element(16'sh5555, 16'shAAAA, 1'b1);
    send_element(16'shAAAA, 16'sh5555, 1'b1);
    // Short vectors with mixed signs.
    send_element(MOST_NEG, 16'sd0, 1'b0);
    send_element(16'sd0, MOST_POS, 1'b1);
    send_element(16'sd0, 16'sd0, 1'b0);
    send_element(16'sd0, 16'sd0, 1'b1);
    send_element(16'sd1234, -16'sd4321, 1'b0);
    send_element(-16'sd20000, 16'sd300, 1'b0);
    send_element(16'sd7, -16'sd32767, 1'b0);
    send_element(MOST_NEG, MOST_NEG, 1'b1);

    // Land exactly on the sum's maximum without passing it: no overflow.
    // 2047 full-scale terms leave 2^31-1, split as 2^31-65535, 65509 and 25.
    repeat (2047) send_element(MOST_NEG, MOST_NEG, 1'b0);
    send_element(MOST_NEG, MOST_POS, 1'b0);
    send_element(-16'sd255, 16'sd22, 1'b0);
    send_element(16'sd3, -16'sd4, 1'b1);

    // Pass the maximum, then keep adding after it has saturated.
    repeat (2048) send_element(MOST_NEG, MOST_NEG, 1'b0);
    repeat (3) send_element(random_part(), random_part(), 1'b0);
    send_element(16'sd7, -16'sd9, 1'b1);
    // The overflow mark must not carry into the next vector.
    send_element(MOST_POS, 16'sd0, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      idle_on = (items_sent < RANDOM_ITEMS - QUIET_TAIL);
      vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < vec_len; k++)
        send_element(random_part(), random_part(), k == vec_len - 1);
      items_sent += vec_len;
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    wait (norms_outstanding == 0);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0 && norms_outstanding == 0) begin
      $display("[complex_vector_euclidean_norm_top] OK");
    end else begin
      $display("[complex_vector_euclidean_norm_top] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[complex_vector_euclidean_norm_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cvnorm_pkg.sv
sv/cvnorm_datapath.sv
sv/cvnorm_ctrl.sv
sv/complex_vector_euclidean_norm_top.sv
test/complex_vector_euclidean_norm_checker.sv
test/complex_vector_euclidean_norm_top_test.sv
